// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the detector modules.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GLMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define GLMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/glmd_pkg.sv =====
package glmd_pkg;

  // Default sizes
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam int SIZE_RST = 1024;

  // Result coordinates
  localparam int COORD_W = 10;

  // Candidate centres decided by one input, in raster order
  localparam int CAND_N      = 4;
  localparam int CAND_UP_LT  = 0;  // (r-1, c-1)
  localparam int CAND_UP_CUR = 1;  // (r-1, c)
  localparam int CAND_CUR_LT = 2;  // (r, c-1)
  localparam int CAND_CUR    = 3;  // (r, c)

  // Position of an input within the grid
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

// ===== rtl/core/glmd_in_if.sv =====
interface glmd_in_if #(
  parameter int SAMPLE_BITS = glmd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/glmd_out_if.sv =====
interface glmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [glmd_pkg::COORD_W-1:0] peak_row;
  logic [glmd_pkg::COORD_W-1:0] peak_col;
  logic                         last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink (input valid, input peak_row, input peak_col, input last_of_run,
                output ready);
endinterface

// ===== rtl/core/glmd_cfg_if.sv =====
interface glmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [glmd_pkg::CFG_ADDR_W-1:0] addr;
  logic [glmd_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ===== rtl/core/glmd_line_mem.sv =====
module glmd_line_mem #(
  parameter int DEPTH  = glmd_pkg::MAX_WIDTH_DEF,
  parameter int DATA_W = 2 * glmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/glmd_window.sv =====
`include "assert_macros.svh"

module glmd_window #(
  parameter int MAX_WIDTH   = glmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = glmd_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = glmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // accepted request from the input stage
  input  logic                            acc,
  input  logic [SAMPLE_BITS-1:0]          acc_sample,
  input  logic [$clog2(MAX_HEIGHT)-1:0]   acc_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]    acc_col,
  input  glmd_pkg::pos_flags_t            acc_flags,
  output logic                            s1_ready,
  // line memory
  input  logic [2*SAMPLE_BITS-1:0]        rd_data,
  output logic                            wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
  output logic [2*SAMPLE_BITS-1:0]        wr_data,
  // candidate bundle to the emitter
  output logic                            bnd_valid,
  input  logic                            bnd_ready,
  output logic [glmd_pkg::CAND_N-1:0]     bnd_mask,
  output logic [$clog2(MAX_HEIGHT)-1:0]   bnd_row,
  output logic [$clog2(MAX_WIDTH)-1:0]    bnd_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef logic [SAMPLE_BITS-1:0] smp_t;
  typedef smp_t win_t [3][3];

  // Centre at window (wr, wc) beats every neighbour that lies inside both
  // the window and the grid; up and left edges come in as flags.
  function automatic logic peak_at(input win_t w, input int wr, input int wc,
                                   input logic has_up, input logic has_left);
    int   nr;
    int   nc;
    logic ok;
    ok = 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = wr + dr;
        nc = wc + dc;
        if (!(dr == 0 && dc == 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2 &&
            (dr != -1 || has_up) && (dc != -1 || has_left)) begin
          if (w[nr][nc] >= w[wr][wc]) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  logic                 s1_vld_r, s1_vld_nxt;
  smp_t                 s1_smp_r;
  logic [RW-1:0]        s1_row_r;
  logic [CW-1:0]        s1_col_r;
  glmd_pkg::pos_flags_t s1_flg_r;
  win_t                 win_r;
  win_t                 win_nxt;
  smp_t                 rd_two;
  smp_t                 rd_one;
  logic [glmd_pkg::CAND_N-1:0] mask;
  logic                 s1_adv;

  assign rd_two = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_one = rd_data[SAMPLE_BITS-1:0];

  // Shift the window left and bring in the new column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = rd_two;
    win_nxt[1][2] = rd_one;
    win_nxt[2][2] = s1_smp_r;
  end

  // Decide the centres whose last neighbour is this input
  always_comb begin
    mask = '0;
    mask[glmd_pkg::CAND_UP_LT] = s1_flg_r.row_ge1 && s1_flg_r.col_ge1 &&
        peak_at(win_nxt, 1, 1, s1_flg_r.row_ge2, s1_flg_r.col_ge2);
    mask[glmd_pkg::CAND_UP_CUR] = s1_flg_r.row_ge1 && s1_flg_r.last_col &&
        peak_at(win_nxt, 1, 2, s1_flg_r.row_ge2, 1'b1);
    mask[glmd_pkg::CAND_CUR_LT] = s1_flg_r.last_row && s1_flg_r.col_ge1 &&
        peak_at(win_nxt, 2, 1, s1_flg_r.row_ge1, s1_flg_r.col_ge2);
    mask[glmd_pkg::CAND_CUR] = s1_flg_r.last_row && s1_flg_r.last_col &&
        peak_at(win_nxt, 2, 2, s1_flg_r.row_ge1, 1'b1);
  end

  // Advance when the emitter takes the bundle or there is nothing to report
  assign s1_adv    = s1_vld_r && (bnd_ready || (mask == '0));
  assign s1_ready  = !s1_vld_r || s1_adv;
  assign bnd_valid = s1_vld_r && (mask != '0);
  assign bnd_mask  = mask;
  assign bnd_row   = s1_row_r;
  assign bnd_col   = s1_col_r;

  // Write back: the row one back moves to two back, the new sample to one back
  assign wr_en   = s1_adv;
  assign wr_addr = s1_col_r;
  assign wr_data = {rd_one, s1_smp_r};

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // Hold the request while it waits for its memory data
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_smp_r <= acc_sample;
      s1_row_r <= acc_row;
      s1_col_r <= acc_col;
      s1_flg_r <= acc_flags;
    end
  end

  // Clear the window on reset, shift it once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  `GLMD_ASSERT_IMPL(a_acc_needs_room, acc, !s1_vld_r || s1_adv,
                    "request taken while the window stage was blocked")

endmodule

// ===== rtl/core/glmd_emit.sv =====
`include "assert_macros.svh"

module glmd_emit #(
  parameter int MAX_WIDTH  = glmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = glmd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          bnd_valid,
  output logic                          bnd_ready,
  input  logic [glmd_pkg::CAND_N-1:0]   bnd_mask,
  input  logic [$clog2(MAX_HEIGHT)-1:0] bnd_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]  bnd_col,
  glmd_out_if.source                    out_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int OW = glmd_pkg::COORD_W;

  logic                        bnd_vld_r, bnd_vld_nxt;
  logic [glmd_pkg::CAND_N-1:0] mask_r, mask_nxt;
  logic [RW-1:0]               row_r;
  logic [CW-1:0]               col_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [OW-1:0]               prow_r, prow_nxt;
  logic [OW-1:0]               pcol_r, pcol_nxt;
  logic                        last_r, last_nxt;
  logic [glmd_pkg::CAND_N-1:0] sel;
  logic [glmd_pkg::CAND_N-1:0] rest;
  logic [RW-1:0]               sel_row;
  logic [CW-1:0]               sel_col;
  logic                        out_load;
  logic                        pop;
  logic                        take;

  // Pick the first pending centre in raster order
  always_comb begin
    sel     = '0;
    sel_row = row_r;
    sel_col = col_r;
    priority if (mask_r[glmd_pkg::CAND_UP_LT]) begin
      sel[glmd_pkg::CAND_UP_LT] = 1'b1;
      sel_row = row_r - RW'(1);
      sel_col = col_r - CW'(1);
    end else if (mask_r[glmd_pkg::CAND_UP_CUR]) begin
      sel[glmd_pkg::CAND_UP_CUR] = 1'b1;
      sel_row = row_r - RW'(1);
    end else if (mask_r[glmd_pkg::CAND_CUR_LT]) begin
      sel[glmd_pkg::CAND_CUR_LT] = 1'b1;
      sel_col = col_r - CW'(1);
    end else begin
      sel[glmd_pkg::CAND_CUR] = 1'b1;
    end
  end

  assign rest      = mask_r & ~sel;
  assign out_load  = !out_vld_r || out_chan.ready;
  assign pop       = bnd_vld_r && out_load;
  assign bnd_ready = !bnd_vld_r || (pop && (rest == '0));
  assign take      = bnd_valid && bnd_ready;

  // Bundle register: load, drain one centre per result
  always_comb begin
    bnd_vld_nxt = bnd_vld_r;
    mask_nxt    = mask_r;
    if (take) begin
      bnd_vld_nxt = 1'b1;
      mask_nxt    = bnd_mask;
    end else if (pop) begin
      bnd_vld_nxt = (rest != '0);
      mask_nxt    = rest;
    end
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    prow_nxt    = prow_r;
    pcol_nxt    = pcol_r;
    last_nxt    = last_r;
    if (pop) begin
      out_vld_nxt = 1'b1;
      prow_nxt    = OW'(sel_row);
      pcol_nxt    = OW'(sel_col);
      last_nxt    = (rest == '0);
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      bnd_vld_r <= bnd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    prow_r <= prow_nxt;
    pcol_r <= pcol_nxt;
    last_r <= last_nxt;
    if (take) begin
      row_r <= bnd_row;
      col_r <= bnd_col;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.peak_row    = prow_r;
  assign out_chan.peak_col    = pcol_r;
  assign out_chan.last_of_run = last_r;

  `GLMD_ASSERT_IMPL(a_bundle_nonempty, bnd_vld_r, mask_r != '0,
                    "bundle held with no pending centre")
  `GLMD_ASSERT(a_run_continues, out_vld_r && out_chan.ready && !last_r |=> out_vld_r,
               "result run broken before its last result")

endmodule

// ===== rtl/core/grid_local_maximum_detector.sv =====
// Path: results pass through the window stage, bundle and output registers.
// Throughput: one request per cycle while results are taken; a request releasing k
//   results keeps the bundle register until all are loaded (k up to 4 at the last row end).
// The line memory gives one read and one write per cycle, which sets the one-per-cycle rate.
// Reset: counters to zero, grid size 1024 by 1024 (clamped to the maximums), pipeline empty.
//   Line memory contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module grid_local_maximum_detector #(
  parameter int MAX_WIDTH   = glmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = glmd_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = glmd_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  glmd_in_if.sink    in_chan,
  glmd_out_if.source out_chan,
  glmd_cfg_if.sink   cfg_chan
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DW  = glmd_pkg::CFG_DATA_W;
  localparam int WWW = (DW > $clog2(MAX_WIDTH + 1)) ? DW : $clog2(MAX_WIDTH + 1);
  localparam int HWW = (DW > $clog2(MAX_HEIGHT + 1)) ? DW : $clog2(MAX_HEIGHT + 1);
  localparam int COL_LAST_RST =
      ((MAX_WIDTH < glmd_pkg::SIZE_RST) ? MAX_WIDTH : glmd_pkg::SIZE_RST) - 1;
  localparam int ROW_LAST_RST =
      ((MAX_HEIGHT < glmd_pkg::SIZE_RST) ? MAX_HEIGHT : glmd_pkg::SIZE_RST) - 1;

  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_last_r, col_last_nxt;
  logic [RW-1:0]        row_last_r, row_last_nxt;
  logic [WWW-1:0]       cfg_w;
  logic [HWW-1:0]       cfg_h;
  logic [CW-1:0]        col_last_cfg;
  logic [RW-1:0]        row_last_cfg;
  logic                 cfg_wr;
  logic                 acc;
  logic                 s1_ready;
  glmd_pkg::pos_flags_t flags;

  logic [2*SAMPLE_BITS-1:0]    rd_data;
  logic                        wr_en;
  logic [CW-1:0]               wr_addr;
  logic [2*SAMPLE_BITS-1:0]    wr_data;
  logic                        bnd_valid;
  logic                        bnd_ready;
  logic [glmd_pkg::CAND_N-1:0] bnd_mask;
  logic [RW-1:0]               bnd_row;
  logic [CW-1:0]               bnd_col;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;
  assign in_chan.ready  = s1_ready;
  assign acc            = in_chan.valid && s1_ready;

  // Clamp written sizes to [2, max] and keep the last index
  assign cfg_w = WWW'(cfg_chan.wdata);
  assign cfg_h = HWW'(cfg_chan.wdata);

  always_comb begin
    if (cfg_w < WWW'(2)) begin
      col_last_cfg = CW'(1);
    end else if (cfg_w > WWW'(MAX_WIDTH)) begin
      col_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_cfg = CW'(cfg_w - WWW'(1));
    end
    if (cfg_h < HWW'(2)) begin
      row_last_cfg = RW'(1);
    end else if (cfg_h > HWW'(MAX_HEIGHT)) begin
      row_last_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last_cfg = RW'(cfg_h - HWW'(1));
    end
  end

  // Position of the incoming request
  always_comb begin
    flags.row_ge1  = (row_r != '0);
    flags.row_ge2  = (row_r > RW'(1));
    flags.col_ge1  = (col_r != '0);
    flags.col_ge2  = (col_r > CW'(1));
    flags.last_row = (row_r == row_last_r);
    flags.last_col = (col_r == col_last_r);
  end

  // Raster counters; a write to the width or height register restarts the frame
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
      unique case (cfg_chan.addr)
        glmd_pkg::REG_GRID_WIDTH: begin
          col_last_nxt = col_last_cfg;
        end
        glmd_pkg::REG_GRID_HEIGHT: begin
          row_last_nxt = row_last_cfg;
        end
        default: begin
          col_nxt = col_r;
          row_nxt = row_r;
        end
      endcase
    end else if (acc) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      col_last_r <= CW'(COL_LAST_RST);
      row_last_r <= RW'(ROW_LAST_RST);
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  glmd_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * SAMPLE_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  glmd_window #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_sample (in_chan.sample),
    .acc_row    (row_r),
    .acc_col    (col_r),
    .acc_flags  (flags),
    .s1_ready   (s1_ready),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .bnd_valid  (bnd_valid),
    .bnd_ready  (bnd_ready),
    .bnd_mask   (bnd_mask),
    .bnd_row    (bnd_row),
    .bnd_col    (bnd_col)
  );

  glmd_emit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .bnd_mask  (bnd_mask),
    .bnd_row   (bnd_row),
    .bnd_col   (bnd_col),
    .out_chan  (out_chan)
  );

  `GLMD_ASSERT(a_col_in_grid, col_r <= col_last_r, "column counter ran past the row end")
  `GLMD_ASSERT(a_row_in_grid, row_r <= row_last_r, "row counter ran past the last row")
  `GLMD_ASSERT(a_row_end_wraps, acc && !cfg_wr && flags.last_col |=> col_r == '0,
               "column counter did not wrap at the row end")

endmodule

// ===== dv/grid_local_maximum_detector_tb.sv =====
module grid_local_maximum_detector_tb;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int MAX_W         = glmd_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H         = glmd_pkg::MAX_HEIGHT_DEF;
  localparam int SMP_W         = glmd_pkg::SAMPLE_BITS_DEF;
  localparam int COORD_W       = glmd_pkg::COORD_W;
  localparam int CFG_ADDR_W    = glmd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W    = glmd_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 170;
  localparam int TALL_ITEMS    = 40;

  // Addresses with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

  typedef logic [SMP_W-1:0]      sample_t;
  typedef logic [CFG_DATA_W-1:0] size_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } peak_t;

  typedef enum {VAL_FULL, VAL_FLAT, VAL_HIGH} value_style_e;
  typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  glmd_in_if #(.SAMPLE_BITS(SMP_W)) in_if ();
  glmd_out_if out_if ();
  glmd_cfg_if cfg_if ();

  grid_local_maximum_detector #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .SAMPLE_BITS(SMP_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Mirror of the detector state
  size_t       width_reg = size_t'(glmd_pkg::SIZE_RST);
  size_t       height_reg = size_t'(glmd_pkg::SIZE_RST);
  sample_t     row_two_back [MAX_W] = '{default: '0};
  sample_t     row_one_back [MAX_W] = '{default: '0};
  sample_t     win [9] = '{default: '0};
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  peak_t peak_q [$];
  int    fail_count = 0;
  int    cycle_count = 0;
  int    burst_left = 0;
  bit    gaps_on = 1'b1;
  bit    hold_req = 1'b0;
  logic  hold_off;

  function automatic int unsigned clamp_dim(input size_t v, input int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  // Centre at window (wr,wc) is grid cell (gr,gc); absent neighbours are skipped
  function automatic bit centre_wins(input int wr, input int wc, input int gr, input int gc,
                                     input int h, input int w);
    sample_t v;
    v = win[wr * 3 + wc];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        if (gr + dr < 0 || gr + dr >= h || gc + dc < 0 || gc + dc >= w) continue;
        if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
        if (win[(wr + dr) * 3 + wc + dc] >= v) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_peaks(input sample_t s);
    int unsigned w;
    int unsigned h;
    int          r;
    int          c;
    int          n;
    int          found;
    bit          last_c;
    bit          last_r;
    int          cw_r [4];
    int          cw_c [4];
    int          cg_r [4];
    int          cg_c [4];
    peak_t       hits [4];
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (cur_col >= w) cur_col = 0;
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;

    // shift the window left and bring in the new column
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = row_two_back[c];
    win[5] = row_one_back[c];
    win[8] = s;
    row_two_back[c] = row_one_back[c];
    row_one_back[c] = s;

    last_c = (c == w - 1);
    last_r = (r == h - 1);

    // list the centres this sample completes, in raster order
    n = 0;
    if (r >= 1 && c >= 1) begin
      cw_r[n] = 1; cw_c[n] = 1; cg_r[n] = r - 1; cg_c[n] = c - 1; n++;
    end
    if (r >= 1 && last_c) begin
      cw_r[n] = 1; cw_c[n] = 2; cg_r[n] = r - 1; cg_c[n] = c; n++;
    end
    if (last_r && c >= 1) begin
      cw_r[n] = 2; cw_c[n] = 1; cg_r[n] = r; cg_c[n] = c - 1; n++;
    end
    if (last_r && last_c) begin
      cw_r[n] = 2; cw_c[n] = 2; cg_r[n] = r; cg_c[n] = c; n++;
    end

    found = 0;
    for (int k = 0; k < n; k++) begin
      if (centre_wins(cw_r[k], cw_c[k], cg_r[k], cg_c[k], h, w)) begin
        hits[found].row  = COORD_W'(cg_r[k]);
        hits[found].col  = COORD_W'(cg_c[k]);
        hits[found].last = 1'b0;
        found++;
      end
    end
    if (found > 0) hits[found - 1].last = 1'b1;
    for (int k = 0; k < found; k++) peak_q.push_back(hits[k]);

    // advance the raster position, wrapping at the end of the frame
    if (last_c) begin
      cur_col = 0;
      cur_row = last_r ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endfunction

  // Track accepted register writes and sample requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.addr)
          glmd_pkg::REG_GRID_WIDTH: begin
            width_reg = cfg_if.wdata;
            cur_row = 0;
            cur_col = 0;
          end
          glmd_pkg::REG_GRID_HEIGHT: begin
            height_reg = cfg_if.wdata;
            cur_row = 0;
            cur_col = 0;
          end
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) predict_peaks(in_if.sample);
    end
  end

  // Compare each accepted peak with the oldest prediction
  always @(posedge clk) begin : check_peaks
    peak_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (peak_q.size() == 0) begin
        $error("unpredicted peak at row %0d col %0d", out_if.peak_row, out_if.peak_col);
        fail_count++;
      end else begin
        want = peak_q.pop_front();
        if (out_if.peak_row !== want.row) begin
          $error("peak_row expected %0d got %0d", want.row, out_if.peak_row);
          fail_count++;
        end
        if (out_if.peak_col !== want.col) begin
          $error("peak_col expected %0d got %0d", want.col, out_if.peak_col);
          fail_count++;
        end
        if (out_if.last_of_run !== want.last) begin
          $error("last_of_run expected %0d got %0d", want.last, out_if.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_local_maximum_detector_tb failed");
      $finish;
    end
  end

  // Stall the result side, switching between patterns
  initial begin : sink_pattern
    sink_mode_e mode;
    int         mode_left;
    int         tick;
    logic       take;
    mode = SINK_OPEN;
    mode_left = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      tick++;
      case (mode)
        SINK_OPEN:     take = 1'b1;
        SINK_COIN:     take = ($urandom_range(0, 1) != 0);
        SINK_MOSTLY:   take = ($urandom_range(0, 9) != 0);
        SINK_PERIODIC: take = ((tick % 8) > 2);
        default:       take = 1'b1;
      endcase
      out_if.ready <= hold_off ? 1'b0 : take;
    end
  end

  // Hold off the result side once for a long stretch
  initial begin
    hold_off <= 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic sample_t pick_sample(input value_style_e style);
    case (style)
      VAL_FLAT: return sample_t'($urandom_range(0, 3));
      VAL_HIGH: return sample_t'(16'hFFFF - $urandom_range(0, 3));
      default:  return sample_t'($urandom);
    endcase
  endfunction

  // Offer one sample request, with a random gap between bursts
  task automatic send_sample(input sample_t s);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
  endtask

  // Wait for every predicted peak, then let in-flight samples settle
  task automatic wait_drain();
    @(posedge clk);
    while (peak_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input size_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_grid(input size_t w, input size_t h);
    wait_drain();
    write_reg(glmd_pkg::REG_GRID_WIDTH, w);
    write_reg(glmd_pkg::REG_GRID_HEIGHT, h);
    cfg_if.valid <= 1'b0;
  endtask

  // Lone centre peak, tied corner, far corner peak, then a clamped 2x2 grid
  task automatic test_directed_frames();
    sample_t lone [9] = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0};
    sample_t ties [9] = '{16'd5, 16'd5, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd9};
    sample_t tiny [4] = '{16'd1, 16'd2, 16'hFFFF, 16'd3};
    gaps_on = 1'b0;
    set_grid(11'd3, 11'd3);
    foreach (lone[i]) send_sample(lone[i]);
    // second frame follows the wrap at the end of the first
    foreach (ties[i]) send_sample(ties[i]);
    release_input();
    set_grid(11'd0, 11'd1);
    foreach (tiny[i]) send_sample(tiny[i]);
    release_input();
  endtask

  // Writes to unused addresses must not restart the frame
  task automatic test_spare_registers();
    gaps_on = 1'b1;
    set_grid(11'd4, 11'd3);
    repeat (5) send_sample(pick_sample(VAL_FULL));
    release_input();
    wait_drain();
    write_reg(REG_SPARE_LO, 11'h7FF);
    write_reg(REG_SPARE_HI, 11'h0);
    cfg_if.valid <= 1'b0;
    repeat (7) send_sample(pick_sample(VAL_FULL));
    release_input();
  endtask

  // Small random grids, partial and multi-frame runs
  task automatic test_random_grids();
    int           sent;
    int           n;
    size_t        w;
    size_t        h;
    value_style_e style;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = size_t'($urandom_range(2, 9));
      h = size_t'($urandom_range(2, 7));
      if ($urandom_range(0, 5) == 0) w = size_t'($urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) h = size_t'($urandom_range(0, 1));
      n = $urandom_range(1, 3 * clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H));
      style = value_style_e'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      set_grid(w, h);
      repeat (n) send_sample(pick_sample(style));
      release_input();
      sent += n;
    end
  endtask

  // Keep offering requests while results are held back
  task automatic test_backpressure();
    gaps_on = 1'b0;
    set_grid(11'd5, 11'd4);
    hold_req = 1'b1;
    repeat (60) send_sample(pick_sample(VAL_FULL));
    release_input();
  endtask

  // Oversize and maximum sizes, then the first rows of the tallest grid
  task automatic test_largest_sizes();
    gaps_on = 1'b1;
    set_grid(11'd2047, 11'd2047);
    repeat (30) send_sample(pick_sample(VAL_FULL));
    release_input();
    set_grid(11'd1024, 11'd1024);
    repeat (20) send_sample(pick_sample(VAL_FULL));
    release_input();
    set_grid(11'd2, 11'd2047);
    repeat (TALL_ITEMS) send_sample(pick_sample(VAL_FULL));
    release_input();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.addr  <= glmd_pkg::REG_GRID_WIDTH;
    cfg_if.wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_spare_registers();
    test_random_grids();
    test_backpressure();
    test_largest_sizes();

    wait_drain();
    if (fail_count == 0 && peak_q.size() == 0) begin
      $display("grid_local_maximum_detector_tb passed");
    end else begin
      $display("grid_local_maximum_detector_tb failed");
    end
    $finish;
  end

endmodule
